### design/sphk_pkg.sv
// ----------------------------------------------------------------------------
// sphk_pkg
// Shared types, codes and fixed-point helpers for the SPH smoothing kernel unit.
// ----------------------------------------------------------------------------
package sphk_pkg;

    // kernel select codes
    localparam logic [2:0] MODE_POLY6       = 3'd0;
    localparam logic [2:0] MODE_POLY6_GRAD  = 3'd1;
    localparam logic [2:0] MODE_SPIKY       = 3'd2;
    localparam logic [2:0] MODE_SPIKY_GRAD  = 3'd3;
    localparam logic [2:0] MODE_VISC        = 3'd4;
    localparam logic [2:0] MODE_VISC_LAP    = 3'd5;

    // configuration register indexes
    localparam logic [3:0] CFG_SUPPORT_RADIUS     = 4'd0;
    localparam logic [3:0] CFG_SUPPORT_RADIUS_SQ  = 4'd1;
    localparam logic [3:0] CFG_THREE_DIMENSIONAL  = 4'd2;
    localparam logic [3:0] CFG_POLY6_SCALE        = 4'd3;
    localparam logic [3:0] CFG_SPIKY_SCALE        = 4'd4;
    localparam logic [3:0] CFG_VISCOSITY_SCALE    = 4'd5;
    localparam logic [3:0] CFG_HALF_INV_RADIUS_CU = 4'd6;
    localparam logic [3:0] CFG_INV_RADIUS_SQ      = 4'd7;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] THREE_Q32 = 64'h0000_0003_0000_0000;
    localparam logic [63:0] SIX_Q32   = 64'h0000_0006_0000_0000;
    localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX   = 64'h8000_0000_0000_0000;
    localparam logic [37:0] TINY_SCALE = 38'd10000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] distance;
        logic [31:0] distance_squared;
    } t_sphk_in;

    typedef struct packed {
        logic signed [63:0] kernel_value;
        logic               saturated;
    } t_sphk_out;

    // per-item context traveling down the pipeline
    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] r;
        logic        act;
        logic        v3;
        logic        neg;
        logic        ovf;
        logic [63:0] t;
        logic [63:0] rw;
        logic [63:0] x;
        logic [63:0] y;
    } t_sphk_ctx;

    // 32x32 partial products of a 64x64 product
    typedef struct packed {
        logic [63:0] p11;
        logic [63:0] p10;
        logic [63:0] p01;
        logic [63:0] p00;
    } t_sphk_pp;

    typedef struct packed {
        logic        ovf;
        logic [63:0] val;
    } t_sphk_qr;

    function automatic t_sphk_pp pp_of(input logic [63:0] a, input logic [63:0] b);
        t_sphk_pp    pp;
        logic [63:0] a0, a1, b0, b1;
        a0 = {32'd0, a[31:0]};
        a1 = {32'd0, a[63:32]};
        b0 = {32'd0, b[31:0]};
        b1 = {32'd0, b[63:32]};
        pp.p00 = a0 * b0;
        pp.p01 = a0 * b1;
        pp.p10 = a1 * b0;
        pp.p11 = a1 * b1;
        return pp;
    endfunction

    // (a*b) >> 32 from partial products, all ones on overflow
    function automatic t_sphk_qr qmul_fin(input t_sphk_pp pp);
        t_sphk_qr    q;
        logic [33:0] mid;
        logic [65:0] hi;
        mid = 34'(pp.p00[63:32]) + 34'(pp.p01[31:0]) + 34'(pp.p10[31:0]);
        hi  = 66'(pp.p11) + 66'(pp.p01[63:32]) + 66'(pp.p10[63:32]) + 66'(mid[33:32]);
        if (|hi[65:32]) begin
            q.ovf = 1'b1;
            q.val = '1;
        end else begin
            q.ovf = 1'b0;
            q.val = {hi[31:0], mid[31:0]};
        end
        return q;
    endfunction

    function automatic t_sphk_qr sat_add(input logic [63:0] a, input logic [63:0] b);
        t_sphk_qr    q;
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64]) begin
            q.ovf = 1'b1;
            q.val = '1;
        end else begin
            q.ovf = 1'b0;
            q.val = s[63:0];
        end
        return q;
    endfunction

endpackage

### design/sphk_div.sv
// ----------------------------------------------------------------------------
// sphk_div
// Pipelined restoring divider, STEP quotient bits per stage, stall by enable.
// ----------------------------------------------------------------------------
module sphk_div #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 25,
    parameter int STEP  = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    localparam int LAT = (NUM_W + STEP - 1) / STEP;

    logic [DEN_W-1:0] r_rem [LAT];
    logic [NUM_W-1:0] r_nq  [LAT];
    logic [DEN_W-1:0] r_den [LAT];

    // remainder in the upper field, dividend bits then quotient bits in the lower
    function automatic logic [DEN_W+NUM_W-1:0] div_steps(
        input logic [DEN_W-1:0] rem_in,
        input logic [NUM_W-1:0] nq_in,
        input logic [DEN_W-1:0] den,
        input int               nsteps
    );
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
        logic [DEN_W:0]   wide;
        rem = rem_in;
        nq  = nq_in;
        for (int k = 0; k < STEP; k++) begin
            if (k < nsteps) begin
                wide = {rem, nq[NUM_W-1]};
                if (wide >= {1'b0, den}) begin
                    wide = wide - {1'b0, den};
                    nq   = {nq[NUM_W-2:0], 1'b1};
                end else begin
                    nq   = {nq[NUM_W-2:0], 1'b0};
                end
                rem = wide[DEN_W-1:0];
            end
        end
        return {rem, nq};
    endfunction

    for (genvar s = 0; s < LAT; s++) begin : g_stage
        localparam int NSTEPS = (NUM_W - s * STEP < STEP) ? NUM_W - s * STEP : STEP;
        logic [DEN_W-1:0]       w_rem_in;
        logic [NUM_W-1:0]       w_nq_in;
        logic [DEN_W-1:0]       w_den_in;
        logic [DEN_W+NUM_W-1:0] n_res;

        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_nq_in  = i_num;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_nq_in  = r_nq[s-1];
            assign w_den_in = r_den[s-1];
        end

        always_comb begin
            n_res = div_steps(w_rem_in, w_nq_in, w_den_in, NSTEPS);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_res[DEN_W+NUM_W-1:NUM_W];
                r_nq[s]  <= n_res[NUM_W-1:0];
                r_den[s] <= w_den_in;
            end
        end
    end

    assign o_quo = r_nq[LAT-1];

endmodule

### design/sph_smoothing_kernel_unit.sv
// ----------------------------------------------------------------------------
// sph_smoothing_kernel_unit
// SPH smoothing kernels (poly6, spiky, viscosity and derivatives) in fixed point.
// ----------------------------------------------------------------------------
// datapath: the four 64x64 multiply steps and the 4-bit-per-stage divider
// throughput: one transaction per cycle, the whole pipeline holds on output stall
// reset: synchronous active low, clears valid bits and loads register defaults
module sph_smoothing_kernel_unit #(
    parameter int DISTANCE_FRACTION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  sphk_pkg::t_sphk_in                   i_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output sphk_pkg::t_sphk_out                  o_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sphk_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sphk_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sphk_pkg::*;

    localparam int F       = DISTANCE_FRACTION_BITS;
    localparam int SH      = 32 - F;
    localparam int NUM_W   = 64 + F;
    localparam int DEN_W   = 25;
    localparam int DIV_LAT = (NUM_W + 3) / 4;
    localparam int NV      = 11 + DIV_LAT;

    // configuration registers
    logic [23:0] r_h;
    logic [31:0] r_h2;
    logic        r_three_d;
    logic [47:0] r_poly6_scale;
    logic [47:0] r_spiky_scale;
    logic [47:0] r_visc_scale;
    logic [47:0] r_hirc;
    logic [47:0] r_irs;

    logic w_adv;
    logic r_vld [NV];

    t_sphk_ctx r_c1, r_c2, r_c3, r_c4, r_c5, r_c6, r_c7, r_c8, r_c9, r_c10;
    t_sphk_ctx n_c1, n_c2, n_c4, n_c6, n_c7, n_c8, n_c10;
    t_sphk_ctx r_dc [DIV_LAT];
    t_sphk_pp  r_pa1, r_pa3, r_pb3, r_pa5, r_pa9;
    logic [63:0] n_a1, n_b1, n_a2, n_b2, n_a3, n_b3, n_a4, n_b4;
    t_sphk_out r_out, n_out;

    logic [NUM_W-1:0] w_div_num;
    logic [DEN_W-1:0] w_div_den;
    logic [NUM_W-1:0] w_quo;

    assign w_adv       = !(r_vld[NV-1] && i_stall);
    assign o_stall     = !w_adv;
    assign o_valid     = r_vld[NV-1];
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h           <= 24'd65536;
            r_h2          <= 32'd65536;
            r_three_d     <= 1'b0;
            r_poly6_scale <= '0;
            r_spiky_scale <= '0;
            r_visc_scale  <= '0;
            r_hirc        <= '0;
            r_irs         <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SUPPORT_RADIUS:     r_h           <= i_cfg_data[23:0];
                CFG_SUPPORT_RADIUS_SQ:  r_h2          <= i_cfg_data[31:0];
                CFG_THREE_DIMENSIONAL:  r_three_d     <= i_cfg_data[0];
                CFG_POLY6_SCALE:        r_poly6_scale <= i_cfg_data;
                CFG_SPIKY_SCALE:        r_spiky_scale <= i_cfg_data;
                CFG_VISCOSITY_SCALE:    r_visc_scale  <= i_cfg_data;
                CFG_HALF_INV_RADIUS_CU: r_hirc        <= i_cfg_data;
                CFG_INV_RADIUS_SQ:      r_irs         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry: support tests, widening, first multiplier operands
    always_comb begin
        logic tiny;
        logic is_p;
        tiny = ((38'(i_data.distance) * TINY_SCALE) < (38'd1 << F));
        is_p = (i_data.mode == MODE_POLY6) || (i_data.mode == MODE_POLY6_GRAD);
        n_c1      = '0;
        n_c1.mode = i_data.mode;
        n_c1.r    = i_data.distance;
        case (i_data.mode)
            MODE_POLY6, MODE_POLY6_GRAD: n_c1.act = i_data.distance_squared < r_h2;
            MODE_SPIKY, MODE_VISC, MODE_VISC_LAP: n_c1.act = i_data.distance < r_h;
            MODE_SPIKY_GRAD: n_c1.act = (i_data.distance < r_h) && !tiny;
            default: n_c1.act = 1'b0;
        endcase
        n_c1.v3  = (i_data.mode == MODE_VISC) && r_three_d;
        n_c1.neg = (i_data.mode == MODE_POLY6_GRAD) || (i_data.mode == MODE_SPIKY_GRAD);
        n_c1.ovf = n_c1.v3 && (i_data.distance == 24'd0);
        n_c1.t   = is_p ? (64'(r_h2 - i_data.distance_squared) << SH)
                        : (64'(r_h - i_data.distance) << SH);
        n_c1.rw  = 64'(i_data.distance) << SH;
        if (n_c1.v3) begin
            n_a1 = n_c1.rw;
            n_b1 = n_c1.rw;
        end else if (i_data.mode == MODE_VISC || i_data.mode == MODE_VISC_LAP) begin
            n_a1 = 64'(r_visc_scale);
            n_b1 = n_c1.t;
        end else begin
            n_a1 = n_c1.t;
            n_b1 = n_c1.t;
        end
    end

    // first product done; second multiply operands
    always_comb begin
        t_sphk_qr q;
        q = qmul_fin(r_pa1);
        n_c2     = r_c1;
        n_c2.x   = q.val;
        n_c2.ovf = r_c1.ovf || q.ovf;
    end

    always_comb begin
        case (r_c2.mode)
            MODE_POLY6_GRAD: begin
                n_a2 = 64'(r_poly6_scale);
                n_b2 = r_c2.x;
            end
            MODE_SPIKY_GRAD: begin
                n_a2 = 64'(r_spiky_scale);
                n_b2 = r_c2.x;
            end
            default: begin
                n_a2 = r_c2.x;
                n_b2 = r_c2.v3 ? r_c2.rw : r_c2.t;
            end
        endcase
    end

    always_comb begin
        t_sphk_qr qa, qb;
        qa = qmul_fin(r_pa3);
        qb = qmul_fin(r_pb3);
        n_c4 = r_c3;
        if (r_c3.mode <= MODE_SPIKY_GRAD || r_c3.v3) begin
            n_c4.x   = qa.val;
            n_c4.ovf = n_c4.ovf || qa.ovf;
        end
        if (r_c3.v3) begin
            n_c4.y   = qb.val;
            n_c4.ovf = n_c4.ovf || qb.ovf;
        end
    end

    // third multiply operands
    always_comb begin
        case (r_c4.mode)
            MODE_POLY6: begin
                n_a3 = 64'(r_poly6_scale);
                n_b3 = r_c4.x;
            end
            MODE_POLY6_GRAD: begin
                n_a3 = r_c4.x;
                n_b3 = r_c4.rw;
            end
            MODE_SPIKY: begin
                n_a3 = 64'(r_spiky_scale);
                n_b3 = r_c4.x;
            end
            MODE_SPIKY_GRAD: begin
                n_a3 = r_c4.x;
                n_b3 = THREE_Q32;
            end
            default: begin
                n_a3 = r_c4.x;
                n_b3 = 64'(r_hirc);
            end
        endcase
    end

    always_comb begin
        t_sphk_qr q;
        q = qmul_fin(r_pa5);
        n_c6 = r_c5;
        if (r_c5.mode <= MODE_SPIKY_GRAD || r_c5.v3) begin
            n_c6.x   = q.val;
            n_c6.ovf = n_c6.ovf || q.ovf;
        end
    end

    // divider: spiky gradient takes num*2^F / r, 3D viscosity takes h*2^32 / 2r
    always_comb begin
        if (r_c6.v3) begin
            w_div_num = NUM_W'({r_h, 32'd0});
            w_div_den = {r_c6.r, 1'b0};
        end else begin
            w_div_num = {r_c6.x, F'(0)};
            w_div_den = {1'b0, r_c6.r};
        end
    end

    sphk_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .STEP  (4)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_div_num),
        .i_den (w_div_den),
        .o_quo (w_quo)
    );

    always_comb begin
        t_sphk_qr pos, ngt;
        t_sphk_ctx c;
        c    = r_dc[DIV_LAT-1];
        pos  = sat_add(c.y, w_quo[63:0]);
        ngt  = sat_add(c.x, ONE_Q32);
        n_c7 = c;
        if (c.mode == MODE_SPIKY_GRAD) begin
            n_c7.ovf = c.ovf || (|w_quo[NUM_W-1:64]);
            n_c7.x   = (|w_quo[NUM_W-1:64]) ? '1 : w_quo[63:0];
        end else if (c.v3) begin
            n_c7.x   = pos.val;
            n_c7.y   = ngt.val;
            n_c7.ovf = c.ovf || pos.ovf || ngt.ovf;
        end
    end

    // signed difference for 3D viscosity as sign and magnitude
    always_comb begin
        n_c8 = r_c7;
        if (r_c7.v3) begin
            if (r_c7.x >= r_c7.y) begin
                n_c8.x = r_c7.x - r_c7.y;
            end else begin
                n_c8.x   = r_c7.y - r_c7.x;
                n_c8.neg = (r_c7.r != 24'd0);
            end
        end
    end

    always_comb begin
        if (r_c8.mode == MODE_POLY6_GRAD) begin
            n_a4 = r_c8.x;
            n_b4 = SIX_Q32;
        end else begin
            n_a4 = 64'(r_visc_scale);
            n_b4 = r_c8.x;
        end
    end

    always_comb begin
        t_sphk_qr q;
        q = qmul_fin(r_pa9);
        n_c10 = r_c9;
        if (r_c9.mode == MODE_POLY6_GRAD || r_c9.v3) begin
            n_c10.x   = q.val;
            n_c10.ovf = n_c10.ovf || q.ovf;
        end
    end

    // sign, clamp and zero outside support
    always_comb begin
        n_out = '0;
        if (r_c10.act) begin
            if (r_c10.neg) begin
                if (r_c10.ovf || r_c10.x > NEG_MAX) begin
                    n_out.kernel_value = NEG_MAX;
                    n_out.saturated    = 1'b1;
                end else begin
                    n_out.kernel_value = 64'd0 - r_c10.x;
                end
            end else begin
                if (r_c10.ovf || r_c10.x[63]) begin
                    n_out.kernel_value = POS_MAX;
                    n_out.saturated    = 1'b1;
                end else begin
                    n_out.kernel_value = r_c10.x;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c1  <= n_c1;
            r_pa1 <= pp_of(n_a1, n_b1);
            r_c2  <= n_c2;
            r_c3  <= r_c2;
            r_pa3 <= pp_of(n_a2, n_b2);
            r_pb3 <= pp_of(r_c2.x, 64'(r_irs));
            r_c4  <= n_c4;
            r_c5  <= r_c4;
            r_pa5 <= pp_of(n_a3, n_b3);
            r_c6  <= n_c6;
            r_dc[0] <= r_c6;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dc[i] <= r_dc[i-1];
            end
            r_c7  <= n_c7;
            r_c8  <= n_c8;
            r_c9  <= r_c8;
            r_pa9 <= pp_of(n_a4, n_b4);
            r_c10 <= n_c10;
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NV; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < NV; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

endmodule

### design/sphk_checker.sv
// ----------------------------------------------------------------------------
// sphk_checker
// Port-level checks of the SPH smoothing kernel unit, bound to the top level.
// ----------------------------------------------------------------------------
module sphk_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input sphk_pkg::t_sphk_out o_data
);
    import sphk_pkg::*;

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("output transaction changed while stalled");

    // input side only waits on a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back pressure");

    // a clamped result sits at one end of the signed range
    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.saturated) |->
            (o_data.kernel_value == POS_MAX || o_data.kernel_value == NEG_MAX))
        else $error("saturated flag without clamped value");

    // a zero result is never flagged
    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kernel_value == 64'd0) |-> !o_data.saturated)
        else $error("zero result flagged as saturated");

endmodule

bind sph_smoothing_kernel_unit sphk_checker u_sphk_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

### tb/sv/sph_smoothing_kernel_checker.sv
// ----------------------------------------------------------------------------
// sph_smoothing_kernel_checker
// Watches the kernel unit's channels, predicts each kernel result from the
// accepted input and the live register copy, and compares results in order.
// ----------------------------------------------------------------------------
module sph_smoothing_kernel_checker
    import sphk_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_in_stall,
    input  t_sphk_in                i_in_data,
    input  logic                    i_out_valid,
    input  logic                    i_stall,
    input  t_sphk_out               i_out_data,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_failures,
    output int                      o_outstanding
);

    localparam int FRAC = 16;

    logic [23:0] radius;
    logic [31:0] radius_sq;
    logic        use_3d;
    logic [47:0] poly6_c, spiky_c, visc_c, half_inv_cube, inv_sq;

    t_sphk_out kernel_q[$];

    // (a*b) >> 32, all ones on overflow
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
                                           inout logic ovf);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (|p[127:96]) begin
            ovf = 1'b1;
            return '1;
        end
        return p[95:32];
    endfunction

    function automatic logic [63:0] fx_add(input logic [63:0] a, input logic [63:0] b,
                                           inout logic ovf);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            ovf = 1'b1;
            return '1;
        end
        return s[63:0];
    endfunction

    function automatic t_sphk_out kernel_prediction(input t_sphk_in it);
        t_sphk_out   res;
        logic [63:0] t, mag, num, q, rem, rw, rsq, rcu, a, b, c, pos, ngt, s, r64;
        logic        ovf, neg, act;
        ovf = 1'b0;
        neg = 1'b0;
        act = 1'b1;
        mag = '0;
        r64 = {40'd0, it.distance};
        rw  = r64 << (32 - FRAC);
        if (it.mode == MODE_POLY6 || it.mode == MODE_POLY6_GRAD) begin
            if (it.distance_squared >= radius_sq) begin
                act = 1'b0;
            end else begin
                t = {32'd0, radius_sq - it.distance_squared} << (32 - FRAC);
                if (it.mode == MODE_POLY6) begin
                    mag = fx_mul(poly6_c, fx_mul(fx_mul(t, t, ovf), t, ovf), ovf);
                end else begin
                    a = fx_mul(poly6_c, fx_mul(t, t, ovf), ovf);
                    a = fx_mul(a, rw, ovf);
                    mag = fx_mul(a, SIX_Q32, ovf);
                    neg = 1'b1;
                end
            end
        end else if (it.mode <= MODE_VISC_LAP) begin
            if (it.distance >= radius) begin
                act = 1'b0;
            end else begin
                t = {40'd0, radius - it.distance} << (32 - FRAC);
                if (it.mode == MODE_SPIKY) begin
                    mag = fx_mul(spiky_c, fx_mul(fx_mul(t, t, ovf), t, ovf), ovf);
                end else if (it.mode == MODE_SPIKY_GRAD) begin
                    // below 0.0001 the gradient is forced to zero
                    if (r64 * 64'd10000 < (64'd1 << FRAC)) begin
                        act = 1'b0;
                    end else begin
                        num = fx_mul(spiky_c, fx_mul(t, t, ovf), ovf);
                        num = fx_mul(num, THREE_Q32, ovf);
                        q   = num / r64;
                        rem = ((num % r64) << FRAC) / r64;
                        if (q > ({64{1'b1}} >> FRAC)) begin
                            ovf = 1'b1;
                            mag = '1;
                        end else begin
                            mag = fx_add(q << FRAC, rem, ovf);
                        end
                        neg = 1'b1;
                    end
                end else if (it.mode == MODE_VISC && use_3d) begin
                    if (it.distance == 0) begin
                        ovf = 1'b1;
                        mag = '1;
                    end else begin
                        rsq = fx_mul(rw, rw, ovf);
                        rcu = fx_mul(rsq, rw, ovf);
                        a   = fx_mul(rcu, half_inv_cube, ovf);
                        b   = fx_mul(rsq, inv_sq, ovf);
                        c   = ({40'd0, radius} << 32) / (r64 << 1);
                        pos = fx_add(b, c, ovf);
                        ngt = fx_add(a, ONE_Q32, ovf);
                        if (pos >= ngt) begin
                            s = pos - ngt;
                        end else begin
                            s = ngt - pos;
                            neg = 1'b1;
                        end
                        mag = fx_mul(visc_c, s, ovf);
                    end
                end else begin
                    mag = fx_mul(visc_c, t, ovf);
                end
            end
        end else begin
            act = 1'b0;
        end

        if (!act) begin
            res.kernel_value = '0;
            res.saturated    = 1'b0;
        end else if (neg) begin
            if (ovf || mag > NEG_MAX) begin
                ovf = 1'b1;
                res.kernel_value = NEG_MAX;
            end else begin
                res.kernel_value = -mag;
            end
            res.saturated = ovf;
        end else begin
            if (ovf || mag > POS_MAX) begin
                ovf = 1'b1;
                res.kernel_value = POS_MAX;
            end else begin
                res.kernel_value = mag;
            end
            res.saturated = ovf;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_sphk_out want;
        if (!i_rst_n) begin
            radius        <= 24'd65536;
            radius_sq     <= 32'd65536;
            use_3d        <= 1'b0;
            poly6_c       <= '0;
            spiky_c       <= '0;
            visc_c        <= '0;
            half_inv_cube <= '0;
            inv_sq        <= '0;
            o_failures    = 0;
            o_outstanding = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SUPPORT_RADIUS:     radius        <= i_cfg_data[23:0];
                    CFG_SUPPORT_RADIUS_SQ:  radius_sq     <= i_cfg_data[31:0];
                    CFG_THREE_DIMENSIONAL:  use_3d        <= i_cfg_data[0];
                    CFG_POLY6_SCALE:        poly6_c       <= i_cfg_data;
                    CFG_SPIKY_SCALE:        spiky_c       <= i_cfg_data;
                    CFG_VISCOSITY_SCALE:    visc_c        <= i_cfg_data;
                    CFG_HALF_INV_RADIUS_CU: half_inv_cube <= i_cfg_data;
                    CFG_INV_RADIUS_SQ:      inv_sq        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) begin
                kernel_q.push_back(kernel_prediction(i_in_data));
            end
            if (i_out_valid && !i_stall) begin
                if (kernel_q.size() == 0) begin
                    o_failures = o_failures + 1;
                    if (o_failures <= 10) begin
                        $display("unexpected result: kernel_value %h saturated %b",
                                 i_out_data.kernel_value, i_out_data.saturated);
                    end
                end else begin
                    want = kernel_q.pop_front();
                    if (i_out_data.kernel_value !== want.kernel_value ||
                        i_out_data.saturated !== want.saturated) begin
                        o_failures = o_failures + 1;
                        if (o_failures <= 10) begin
                            $display("mismatch: kernel_value %h saturated %b, expected %h %b",
                                     i_out_data.kernel_value, i_out_data.saturated,
                                     want.kernel_value, want.saturated);
                        end
                    end
                end
            end
            o_outstanding = kernel_q.size();
        end
    end

endmodule

### tb/sv/sph_smoothing_kernel_unit_tb.sv
// ----------------------------------------------------------------------------
// sph_smoothing_kernel_unit_tb
// Loads several register settings, from defaults to extremes, and streams
// directed and random kernel requests under varying idle and stall pressure.
// ----------------------------------------------------------------------------
module sph_smoothing_kernel_unit_tb;
    import sphk_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_sphk_in              i_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_sphk_out             o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int failures;
    int outstanding;
    int sent_count = 0;
    int src_idle_pct = 16;
    int sink_stall_pct = 88;
    logic [23:0] cur_radius = 24'd65536;

    always #4 i_clk = ~i_clk;

    sph_smoothing_kernel_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    sph_smoothing_kernel_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_stall(i_stall), .i_out_data(o_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_failures(failures), .o_outstanding(outstanding)
    );

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    initial begin
        #(8 * 400000);
        $display("sph_smoothing_kernel_unit_tb failed");
        $finish;
    end

    task automatic send_request(input logic [2:0] mode, input logic [23:0] req_dist,
                                input logic [31:0] req_dist_sq);
        t_sphk_in req;
        req.mode             = mode;
        req.distance         = req_dist;
        req.distance_squared = req_dist_sq;
        // idle and stall pressure follow the run's progress
        if (sent_count == 180) begin
            src_idle_pct   = 88;
            sink_stall_pct = 16;
        end else if (sent_count == 360) begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    task automatic send_random(input int count);
        logic [23:0] r;
        logic [31:0] rsq;
        logic [47:0] prod;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: r = (cur_radius == 0) ? 24'd0
                                      : 24'($urandom_range(0, cur_radius - 1));
                6: r = 24'($urandom_range(0, 20));
                default: r = 24'($urandom);
            endcase
            prod = {24'd0, r} * {24'd0, r};
            rsq = ($urandom_range(0, 4) == 0) ? 32'($urandom) : prod[47:16];
            send_request(3'($urandom_range(0, 7)), r, rsq);
        end
    endtask

    // waits for all results and lets the pipeline settle before register writes
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_setting(input logic [23:0] h, input logic [31:0] h2,
                                input logic d3, input logic [47:0] p6,
                                input logic [47:0] sp, input logic [47:0] vs,
                                input logic [47:0] hic, input logic [47:0] irs);
        drain();
        reg_write(CFG_SUPPORT_RADIUS, {24'd0, h});
        reg_write(CFG_SUPPORT_RADIUS_SQ, {16'd0, h2});
        reg_write(CFG_THREE_DIMENSIONAL, {47'd0, d3});
        reg_write(CFG_POLY6_SCALE, p6);
        reg_write(CFG_SPIKY_SCALE, sp);
        reg_write(CFG_VISCOSITY_SCALE, vs);
        reg_write(CFG_HALF_INV_RADIUS_CU, hic);
        reg_write(CFG_INV_RADIUS_SQ, irs);
        i_cfg_valid <= 1'b0;
        cur_radius = h;
    endtask

    initial begin
        logic [23:0] h;
        logic [47:0] hh;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: all scales zero
        send_request(MODE_POLY6, 24'd32768, 32'd16384);
        send_request(MODE_VISC, 24'd100, 32'd0);

        load_setting(24'd65536, 32'd65536, 1'b0, 48'h4_0000_0000, 48'hA_0000_0000,
                     48'h3_0000_0000, 48'd0, 48'd0);
        send_request(MODE_POLY6, 24'd32768, 32'd16384);
        send_request(MODE_POLY6_GRAD, 24'd32768, 32'd16384);
        send_request(MODE_SPIKY, 24'd32768, 32'd16384);
        send_request(MODE_SPIKY_GRAD, 24'd32768, 32'd16384);
        send_request(MODE_VISC, 24'd32768, 32'd16384);
        send_request(MODE_VISC_LAP, 24'd32768, 32'd16384);
        send_request(3'd6, 24'd32768, 32'd16384);
        send_request(3'd7, 24'd32768, 32'd16384);
        send_request(MODE_POLY6, 24'd0, 32'd0);
        send_request(MODE_SPIKY, 24'd0, 32'd0);
        send_request(MODE_VISC_LAP, 24'd0, 32'd0);
        // support edge: exactly at h, and one below
        send_request(MODE_POLY6, 24'd65536, 32'd65536);
        send_request(MODE_SPIKY, 24'd65536, 32'd65535);
        send_request(MODE_POLY6_GRAD, 24'd65535, 32'd65535);
        // spiky gradient around the tiny distance limit
        send_request(MODE_SPIKY_GRAD, 24'd6, 32'd0);
        send_request(MODE_SPIKY_GRAD, 24'd7, 32'd0);
        send_request(MODE_SPIKY_GRAD, 24'd0, 32'd0);
        send_request(MODE_VISC, 24'hFFFFFF, 32'hFFFFFFFF);
        send_random(100);

        // unmapped register index must change nothing
        drain();
        reg_write(4'd9, 48'hFFFF_FFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_random(10);

        load_setting(24'd131072, 32'd262144, 1'b1, 48'h0_8000_0000, 48'h2_0000_0000,
                     48'h5_0000_0000, 48'h0_1000_0000, 48'h0_4000_0000);
        send_request(MODE_VISC, 24'd0, 32'd0);
        send_request(MODE_VISC, 24'd1, 32'd0);
        send_request(MODE_VISC, 24'd65536, 32'd65536);
        send_request(MODE_VISC_LAP, 24'd65536, 32'd65536);
        send_random(120);

        load_setting(24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 48'hFFFF_FFFF_FFFF,
                     48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                     48'hFFFF_FFFF_FFFF);
        send_request(MODE_POLY6, 24'd0, 32'd0);
        send_request(MODE_POLY6_GRAD, 24'd1, 32'd1);
        send_request(MODE_SPIKY_GRAD, 24'd7, 32'd0);
        send_random(100);

        load_setting(24'd0, 32'd0, 1'b0, 48'($urandom), 48'($urandom), 48'($urandom),
                     48'($urandom), 48'($urandom));
        send_random(40);

        // random moderate settings
        repeat (2) begin
            h  = 24'($urandom_range(256, 1 << 20));
            hh = {24'd0, h} * {24'd0, h};
            load_setting(h, hh[47:16], 1'($urandom),
                         {16'($urandom), 32'($urandom)} >> $urandom_range(0, 40),
                         {16'($urandom), 32'($urandom)} >> $urandom_range(0, 40),
                         {16'($urandom), 32'($urandom)} >> $urandom_range(0, 40),
                         {16'($urandom), 32'($urandom)} >> $urandom_range(0, 40),
                         {16'($urandom), 32'($urandom)} >> $urandom_range(0, 40));
            send_random(80);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (40) @(posedge i_clk);
        if (failures == 0) begin
            $display("sph_smoothing_kernel_unit_tb passed");
        end else begin
            $display("sph_smoothing_kernel_unit_tb failed");
        end
        $finish;
    end

endmodule

### sph_smoothing_kernel_unit.f
design/sphk_pkg.sv
design/sphk_div.sv
design/sph_smoothing_kernel_unit.sv
design/sphk_checker.sv
tb/sv/sph_smoothing_kernel_checker.sv
tb/sv/sph_smoothing_kernel_unit_tb.sv
